// File: hw/rtl/rfd_pkg.sv
package rfd_pkg;

  localparam int unsigned BODY_MIN    = 16;
  localparam int unsigned MAGIC_BYTES = 8;

  typedef enum logic [3:0] {
    PH_LEN     = 4'd0,
    PH_MAGIC   = 4'd1,
    PH_TYPE    = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_STREAM  = 4'd4,
    PH_METALEN = 4'd5,
    PH_KEYLEN  = 4'd6,
    PH_KEY     = 4'd7,
    PH_VALLEN  = 4'd8,
    PH_VAL     = 4'd9,
    PH_PAYLOAD = 4'd10,
    PH_SKIP    = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_KEYLEN  = 3'd1,
    KIND_KEYBYTE = 3'd2,
    KIND_VALLEN  = 3'd3,
    KIND_VALBYTE = 3'd4,
    KIND_PAYLOAD = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ERR_LEN_SMALL   = 3'd0,
    ERR_BAD_MAGIC   = 3'd1,
    ERR_META_LONG   = 3'd2,
    ERR_KEY_OVERRUN = 3'd3,
    ERR_VLEN_OVER   = 3'd4,
    ERR_VAL_OVERRUN = 3'd5
  } err_t;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [7:0]  data_byte;
    logic [15:0] field_length;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] stream_number;
    logic [31:0] body_length;
    logic [2:0]  error_code;
    logic        frame_end;
  } res_t;

endpackage

// File: hw/rtl/rfd_if.sv
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [7:0]  data_byte;
  logic [15:0] field_length;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [31:0] stream_number;
  logic [31:0] body_length;
  logic [2:0]  error_code;
  logic        frame_end;

  modport source (output valid, output item_kind, output data_byte, output field_length,
                  output frame_type, output frame_flags, output stream_number,
                  output body_length, output error_code, output frame_end, input ready);
  modport sink (input valid, input item_kind, input data_byte, input field_length,
                input frame_type, input frame_flags, input stream_number,
                input body_length, input error_code, input frame_end, output ready);
endinterface

interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] magic_word;

  modport source (output valid, output magic_word, input ready);
  modport sink (input valid, input magic_word, output ready);
endinterface

// File: hw/rtl/rfd_parser.sv
module rfd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic [7:0]    byte_in,
  input  logic [63:0]   magic_word,
  output logic          res_valid,
  output rfd_pkg::res_t res
);
  import rfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fbc_r, fbc_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] frame_left_r, frame_left_nxt;
  logic [15:0] meta_left_r, meta_left_nxt;
  logic [15:0] item_left_r, item_left_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [7:0]  held_flags_r, held_flags_nxt;
  logic [31:0] held_stream_r, held_stream_nxt;
  logic [31:0] held_length_r, held_length_nxt;
  logic        magic_match_r, magic_match_nxt;

  logic [31:0] shifted;
  logic [31:0] frame_dec;
  logic [15:0] meta_dec;
  logic [15:0] item_dec;
  logic [7:0]  want;
  logic        hdr;

  assign shifted   = {shift_r[23:0], byte_in};
  assign frame_dec = frame_left_r - 32'd1;
  assign meta_dec  = meta_left_r - 16'd1;
  assign item_dec  = item_left_r - 16'd1;
  assign want      = magic_word[{~fbc_r, 3'b000} +: 8];

  always_comb begin
    phase_nxt       = phase_r;
    fbc_nxt         = fbc_r;
    shift_nxt       = shift_r;
    frame_left_nxt  = frame_dec;
    meta_left_nxt   = meta_left_r;
    item_left_nxt   = item_left_r;
    held_type_nxt   = held_type_r;
    held_flags_nxt  = held_flags_r;
    held_stream_nxt = held_stream_r;
    held_length_nxt = held_length_r;
    magic_match_nxt = magic_match_r;
    res_valid       = 1'b0;
    hdr             = 1'b0;
    res             = '0;

    unique case (phase_r)
      PH_LEN: begin
        frame_left_nxt = frame_left_r;
        shift_nxt      = shifted;
        if (fbc_r < 3'd3) begin
          fbc_nxt = fbc_r + 3'd1;
        end else begin
          fbc_nxt         = '0;
          held_length_nxt = shifted;
          frame_left_nxt  = shifted;
          if (shifted < 32'(BODY_MIN)) begin
            res_valid      = 1'b1;
            res.item_kind  = KIND_ERROR;
            res.error_code = ERR_LEN_SMALL;
            phase_nxt      = (shifted != '0) ? PH_SKIP : PH_LEN;
          end else begin
            phase_nxt       = PH_MAGIC;
            magic_match_nxt = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (frame_dec == '0) phase_nxt = PH_LEN;
      end
      PH_MAGIC: begin
        magic_match_nxt = magic_match_r & (want == byte_in);
        if (fbc_r < 3'(MAGIC_BYTES - 1)) begin
          fbc_nxt = fbc_r + 3'd1;
        end else begin
          fbc_nxt = '0;
          if (!magic_match_nxt) begin
            res_valid      = 1'b1;
            res.item_kind  = KIND_ERROR;
            res.error_code = ERR_BAD_MAGIC;
            phase_nxt      = (frame_dec != '0) ? PH_SKIP : PH_LEN;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        held_type_nxt = byte_in;
        phase_nxt     = PH_FLAGS;
      end
      PH_FLAGS: begin
        held_flags_nxt = byte_in;
        phase_nxt      = PH_STREAM;
      end
      PH_STREAM: begin
        shift_nxt = shifted;
        if (fbc_r < 3'd3) begin
          fbc_nxt = fbc_r + 3'd1;
        end else begin
          fbc_nxt         = '0;
          held_stream_nxt = shifted;
          phase_nxt       = PH_METALEN;
        end
      end
      PH_METALEN: begin
        shift_nxt = shifted;
        if (fbc_r < 3'd1) begin
          fbc_nxt = fbc_r + 3'd1;
        end else begin
          fbc_nxt       = '0;
          meta_left_nxt = shifted[15:0];
          res_valid     = 1'b1;
          if ({16'd0, shifted[15:0]} > frame_dec) begin
            res.item_kind  = KIND_ERROR;
            res.error_code = ERR_META_LONG;
            phase_nxt      = (frame_dec != '0) ? PH_SKIP : PH_LEN;
          end else begin
            res.item_kind    = KIND_HEADER;
            res.field_length = shifted[15:0];
            hdr              = 1'b1;
            if (shifted[15:0] != '0) phase_nxt = PH_KEYLEN;
            else phase_nxt = (frame_dec != '0) ? PH_PAYLOAD : PH_LEN;
          end
        end
      end
      PH_KEYLEN: begin
        meta_left_nxt = meta_dec;
        res_valid     = 1'b1;
        if ({8'd0, byte_in} > meta_dec) begin
          res.item_kind  = KIND_ERROR;
          res.error_code = ERR_KEY_OVERRUN;
          phase_nxt      = (frame_dec != '0) ? PH_SKIP : PH_LEN;
          fbc_nxt        = '0;
        end else if (({9'd0, byte_in} + 17'd2) > {1'b0, meta_dec}) begin
          res.item_kind  = KIND_ERROR;
          res.error_code = ERR_VLEN_OVER;
          phase_nxt      = (frame_dec != '0) ? PH_SKIP : PH_LEN;
          fbc_nxt        = '0;
        end else begin
          item_left_nxt    = {8'd0, byte_in};
          fbc_nxt          = '0;
          phase_nxt        = (byte_in != '0) ? PH_KEY : PH_VALLEN;
          res.item_kind    = KIND_KEYLEN;
          res.field_length = {8'd0, byte_in};
        end
      end
      PH_KEY: begin
        meta_left_nxt = meta_dec;
        item_left_nxt = item_dec;
        if (item_dec == '0) begin
          phase_nxt = PH_VALLEN;
          fbc_nxt   = '0;
        end
        res_valid     = 1'b1;
        res.item_kind = KIND_KEYBYTE;
        res.data_byte = byte_in;
      end
      PH_VALLEN: begin
        meta_left_nxt = meta_dec;
        shift_nxt     = shifted;
        if (fbc_r < 3'd1) begin
          fbc_nxt = fbc_r + 3'd1;
        end else begin
          fbc_nxt       = '0;
          item_left_nxt = shifted[15:0];
          res_valid     = 1'b1;
          if (shifted[15:0] > meta_dec) begin
            res.item_kind  = KIND_ERROR;
            res.error_code = ERR_VAL_OVERRUN;
            phase_nxt      = (frame_dec != '0) ? PH_SKIP : PH_LEN;
          end else begin
            res.item_kind    = KIND_VALLEN;
            res.field_length = shifted[15:0];
            if (shifted[15:0] != '0) phase_nxt = PH_VAL;
            else if (meta_dec != '0) phase_nxt = PH_KEYLEN;
            else phase_nxt = (frame_dec != '0) ? PH_PAYLOAD : PH_LEN;
          end
        end
      end
      PH_VAL: begin
        meta_left_nxt = meta_dec;
        item_left_nxt = item_dec;
        if (item_dec == '0) begin
          if (meta_dec != '0) phase_nxt = PH_KEYLEN;
          else phase_nxt = (frame_dec != '0) ? PH_PAYLOAD : PH_LEN;
        end
        res_valid     = 1'b1;
        res.item_kind = KIND_VALBYTE;
        res.data_byte = byte_in;
      end
      PH_PAYLOAD: begin
        if (frame_dec == '0) phase_nxt = PH_LEN;
        res_valid     = 1'b1;
        res.item_kind = KIND_PAYLOAD;
        res.data_byte = byte_in;
      end
      default: begin
        // unknown phase: restart and take this byte as the first length byte
        frame_left_nxt = frame_left_r;
        shift_nxt      = shifted;
        phase_nxt      = PH_LEN;
        fbc_nxt        = 3'd1;
      end
    endcase

    if (hdr) begin
      res.frame_type    = held_type_r;
      res.frame_flags   = held_flags_r;
      res.stream_number = held_stream_r;
    end
    res.body_length = held_length_nxt;
    res.frame_end   = (frame_left_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEN;
      fbc_r         <= '0;
      shift_r       <= '0;
      frame_left_r  <= '0;
      meta_left_r   <= '0;
      item_left_r   <= '0;
      held_type_r   <= '0;
      held_flags_r  <= '0;
      held_stream_r <= '0;
      held_length_r <= '0;
      magic_match_r <= 1'b1;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      fbc_r         <= fbc_nxt;
      shift_r       <= shift_nxt;
      frame_left_r  <= frame_left_nxt;
      meta_left_r   <= meta_left_nxt;
      item_left_r   <= item_left_nxt;
      held_type_r   <= held_type_nxt;
      held_flags_r  <= held_flags_nxt;
      held_stream_r <= held_stream_nxt;
      held_length_r <= held_length_nxt;
      magic_match_r <= magic_match_nxt;
    end
  end

endmodule

// File: hw/rtl/rpc_frame_deframer.sv
// Frame deframer for a byte stream of length-prefixed frames.
// in_chan carries one stream byte per item. out_chan carries at most one
// result item per input byte: header, key/value lengths, key, value and
// payload bytes, or an error; frame_end marks the item from the body's last
// byte. Skipped bytes give none; length/magic/header bytes only error/header.
// cfg_chan writes the 64-bit expected magic; it is always ready and should
// be written only while no frame is in flight.
// An accepted byte sits in the input register and is parsed into the output
// register when that register is free or draining, and its result is then
// presented from the output register.
// Throughput: one byte per cycle unless out_chan stalls; the parse state
// update is one pass of compares and counter decrements between registers.
// When out_chan stalls, the result holds and one more byte is still taken
// into the input register; in_chan.ready then drops until the result leaves.
// Reset (synchronous, rst_n low) empties both registers, clears the parse
// state to wait for a length word and sets the magic register to zero.
module rpc_frame_deframer (
  input  logic clk,
  input  logic rst_n,
  rfd_in_if.sink    in_chan,
  rfd_out_if.source out_chan,
  rfd_cfg_if.sink   cfg_chan
);
  import rfd_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  res_t        out_res_r;
  logic [63:0] magic_word_r;
  logic        advance;
  logic        res_valid;
  res_t        res;

  // parse the held byte only when the output slot is free or draining
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r <= '0;
    end else if (cfg_chan.valid) begin
      magic_word_r <= cfg_chan.magic_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) in_byte_r <= in_chan.in_byte;
  end

  rfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .byte_in    (in_byte_r),
    .magic_word (magic_word_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) out_res_r <= res;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.item_kind     = out_res_r.item_kind;
  assign out_chan.data_byte     = out_res_r.data_byte;
  assign out_chan.field_length  = out_res_r.field_length;
  assign out_chan.frame_type    = out_res_r.frame_type;
  assign out_chan.frame_flags   = out_res_r.frame_flags;
  assign out_chan.stream_number = out_res_r.stream_number;
  assign out_chan.body_length   = out_res_r.body_length;
  assign out_chan.error_code    = out_res_r.error_code;
  assign out_chan.frame_end     = out_res_r.frame_end;

endmodule

// File: hw/rtl/rfd_checker.sv
module rfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  item_kind,
  input logic [7:0]  data_byte,
  input logic [15:0] field_length,
  input logic [7:0]  frame_type,
  input logic [7:0]  frame_flags,
  input logic [31:0] stream_number,
  input logic [2:0]  error_code
);
  import rfd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(data_byte)
      && $stable(field_length) && $stable(error_code))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind == KIND_ERROR |-> data_byte == '0 && field_length == '0
      && stream_number == '0)
    else $error("error item carries data");

  a_hdr_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind != KIND_HEADER |-> frame_type == '0 && frame_flags == '0
      && stream_number == '0)
    else $error("header fields on non-header item");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind != KIND_ERROR |-> error_code == '0)
    else $error("error code on non-error item");

endmodule

bind rpc_frame_deframer rfd_checker u_rfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .item_kind     (out_chan.item_kind),
  .data_byte     (out_chan.data_byte),
  .field_length  (out_chan.field_length),
  .frame_type    (out_chan.frame_type),
  .frame_flags   (out_chan.frame_flags),
  .stream_number (out_chan.stream_number),
  .error_code    (out_chan.error_code)
);
